>>> rtl/core/ctsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctsd_pkg;

  localparam int HISTORY_DEPTH    = 32;
  localparam int TICKS_PER_SECOND = 4000000;

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int DEG_W = 10 + CNT_W;
  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int NUM_W = TPS_W + DEG_W;
  localparam int DEN_W = 35;
  localparam int REM_W = DEN_W + 16;

  localparam logic [10:0] ANGLE_ONE = 11'd720;
  localparam logic [10:0] ANGLE_TWO = 11'd1440;

  localparam logic [2:0] LOSS_NONE      = 3'd0;
  localparam logic [2:0] LOSS_EXPIRED   = 3'd1;
  localparam logic [2:0] LOSS_VARIATION = 3'd2;
  localparam logic [2:0] LOSS_HIGH      = 3'd3;
  localparam logic [2:0] LOSS_LOW       = 3'd4;

  typedef enum logic [1:0] {
    ACT_TRIG   = 2'd0,
    ACT_SYNC   = 2'd1,
    ACT_EXPIRY = 2'd2,
    ACT_IGNORE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_NOSYNC = 2'd0,
    ST_RPM    = 2'd1,
    ST_SYNC   = 2'd2
  } sync_t;

  typedef enum logic [2:0] {
    CFG_MODE       = 3'd0,
    CFG_REQ_TEETH  = 3'd1,
    CFG_DEG_TOOTH  = 3'd2,
    CFG_RPM_WINDOW = 3'd3,
    CFG_TEETH_CYC  = 3'd4,
    CFG_MIN_RPM    = 3'd5,
    CFG_MAX_CHANGE = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_DECIDE,
    C_RD_SLICE,
    C_LD_SLICE,
    C_DIV_SLICE,
    C_LD_WIN,
    C_DIV_WIN,
    C_MUL_CHK,
    C_CHK,
    C_POST,
    C_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] event_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  sync_state;
    logic        position_valid;
    logic [2:0]  loss_reason;
    logic [15:0] engine_rpm;
    logic [9:0]  crank_angle;
    logic [31:0] expiry_time;
    logic [31:0] last_tooth_time;
  } res_t;

  typedef struct packed {
    logic accept;
    logic sel_win;
    logic ld_deg_slice;
    logic ld_deg_win;
    logic ld_diff;
    logic div_start;
    logic take_slice;
    logic zero_rpm;
    logic take_rpm;
    logic mul_chk;
    logic chk;
    logic post;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_rpm;
    logic win_ok;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/core/ctsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ctsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/ctsd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ctsd_div
  import ctsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [15:0]           quot
);

  logic             busy;
  logic [4:0]       cnt;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dsh;
  logic [15:0]      q;
  logic             sat;

  // control: one saturation check, then sixteen quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

  // restoring division, one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(num);
      dsh <= {den, 16'h0000};
      q   <= 16'h0000;
      sat <= 1'b0;
    end else if (busy) begin
      if (cnt == 5'd0) begin
        sat <= (rem >= dsh);
      end else if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[14:0], 1'b1};
      end else begin
        q   <= {q[14:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign quot = sat ? 16'hFFFF : q;

endmodule
`default_nettype wire

>>> rtl/core/ctsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ctsd_ctrl
  import ctsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE:      if (req_valid) state_next = C_DECIDE;
      C_DECIDE:    state_next = status.need_rpm ? C_RD_SLICE : C_POST;
      C_RD_SLICE:  state_next = C_LD_SLICE;
      C_LD_SLICE:  state_next = C_DIV_SLICE;
      C_DIV_SLICE: begin
        if (status.div_done) state_next = status.win_ok ? C_LD_WIN : C_MUL_CHK;
      end
      C_LD_WIN:    state_next = C_DIV_WIN;
      C_DIV_WIN:   if (status.div_done) state_next = C_MUL_CHK;
      C_MUL_CHK:   state_next = C_CHK;
      C_CHK:       state_next = C_POST;
      C_POST:      state_next = C_DONE;
      C_DONE:      if (status.out_free) state_next = C_IDLE;
      default:     state_next = C_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      C_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      C_DECIDE:   ;
      C_RD_SLICE: cmd.ld_deg_slice = 1'b1;
      C_LD_SLICE: begin
        cmd.ld_diff   = 1'b1;
        cmd.div_start = 1'b1;
      end
      C_DIV_SLICE: begin
        cmd.sel_win    = 1'b1;
        cmd.ld_deg_win = 1'b1;
        cmd.take_slice = status.div_done;
        cmd.zero_rpm   = status.div_done & ~status.win_ok;
      end
      C_LD_WIN:  cmd.div_start = 1'b1;
      C_DIV_WIN: cmd.take_rpm  = status.div_done;
      C_MUL_CHK: cmd.mul_chk   = 1'b1;
      C_CHK:     cmd.chk       = 1'b1;
      C_POST:    cmd.post      = 1'b1;
      C_DONE:    cmd.out_load  = status.out_free;
      default:   ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/ctsd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ctsd_dp
  import ctsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire req_t        req,
  output res_t             res,
  output logic             res_valid,
  input  wire logic        res_ready,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic        mode;
  logic [5:0]  req_teeth;
  logic [9:0]  dpt;
  logic [5:0]  rpm_window;
  logic [7:0]  teeth_cyc;
  logic [15:0] min_rpm;
  logic [15:0] max_change;

  // decoder state
  sync_t            st;
  sync_t            old_st;
  act_t             act_reg;
  logic [CNT_W-1:0] tc;
  logic [7:0]       tss;
  logic [9:0]       angle;
  logic [15:0]      rpm;
  logic [2:0]       loss;
  logic             valid;
  logic [31:0]      expiry;
  logic [31:0]      last_time;
  logic [31:0]      t0;
  logic [PTR_W-1:0] hd;

  // working registers
  logic [DEG_W-1:0] deg;
  logic [31:0]      diff;
  logic [15:0]      slice;
  logic [32:0]      up_lim;
  logic [32:0]      lo_lim;

  logic [31:0]      rdata;
  logic [PTR_W-1:0] raddr;
  logic             push;
  logic [15:0]      quot;
  logic             div_done;

  logic [CNT_W-1:0] tc_inc;
  logic [7:0]       tss_inc;
  logic [10:0]      ang_sum;
  logic [9:0]       ang_wrap;
  logic [7:0]       w_full;
  logic [7:0]       w_m1;
  logic [31:0]      diff_cur;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [16:0]      up_f;
  logic [16:0]      lo_f;
  logic [32:0]      s_cmp;
  logic             var_fail;

  always_comb begin
    tc_inc  = (8'(tc) < 8'(HISTORY_DEPTH)) ? tc + CNT_W'(1) : tc;
    tss_inc = (tss != 8'hFF) ? tss + 8'd1 : tss;
    ang_sum = {1'b0, angle} + {1'b0, dpt};
    if (ang_sum >= ANGLE_TWO) begin
      ang_wrap = 10'(ang_sum - ANGLE_TWO);
    end else if (ang_sum >= ANGLE_ONE) begin
      ang_wrap = 10'(ang_sum - ANGLE_ONE);
    end else begin
      ang_wrap = ang_sum[9:0];
    end
    w_full   = (8'(tc) < 8'(rpm_window)) ? 8'(tc) : 8'(rpm_window);
    w_m1     = w_full - 8'd1;
    raddr    = cmd.sel_win ? hd - w_m1[PTR_W-1:0] : hd - PTR_W'(1);
    diff_cur = t0 - rdata;
    num      = NUM_W'(TICKS_PER_SECOND) * NUM_W'(deg);
    den      = DEN_W'({diff_cur, 2'b00}) + DEN_W'({diff_cur, 1'b0});
    up_f     = 17'h10000 + 17'(max_change);
    lo_f     = 17'h10000 - 17'(max_change);
    s_cmp    = 33'({slice, 16'h0000});
    var_fail = (slice <= min_rpm) || (s_cmp > up_lim) || (s_cmp < lo_lim);
    push     = cmd.accept && (act_t'(req.action) == ACT_TRIG);
  end

  assign status.need_rpm = (act_reg == ACT_TRIG) && (st != ST_NOSYNC);
  assign status.win_ok   = (w_full > 8'd1);
  assign status.div_done = div_done;
  assign status.out_free = ~res_valid | res_ready;

  ctsd_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (push),
    .waddr (hd + PTR_W'(1)),
    .wdata (req.event_time),
    .raddr (raddr),
    .rdata (rdata)
  );

  ctsd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      req_teeth  <= 6'd4;
      dpt        <= 10'd90;
      rpm_window <= 6'd3;
      teeth_cyc  <= 8'd8;
      min_rpm    <= 16'd0;
      max_change <= 16'd32768;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:       mode       <= cfg_data[0];
        CFG_REQ_TEETH:  req_teeth  <= cfg_data[5:0];
        CFG_DEG_TOOTH:  dpt        <= cfg_data[9:0];
        CFG_RPM_WINDOW: rpm_window <= cfg_data[5:0];
        CFG_TEETH_CYC:  teeth_cyc  <= cfg_data[7:0];
        CFG_MIN_RPM:    min_rpm    <= cfg_data;
        CFG_MAX_CHANGE: max_change <= cfg_data;
        default:        ;
      endcase
    end
  end

  // decoder state: event intake, rpm check, final sync decision
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_NOSYNC;
      old_st    <= ST_NOSYNC;
      act_reg   <= ACT_IGNORE;
      tc        <= '0;
      tss       <= 8'd0;
      angle     <= 10'd0;
      rpm       <= 16'd0;
      loss      <= LOSS_NONE;
      valid     <= 1'b0;
      expiry    <= 32'd0;
      last_time <= 32'd0;
      hd        <= '0;
    end else if (cmd.accept) begin
      act_reg <= act_t'(req.action);
      old_st  <= st;
      unique case (act_t'(req.action))
        ACT_EXPIRY: begin
          loss  <= LOSS_EXPIRED;
          valid <= 1'b0;
          st    <= ST_NOSYNC;
          tc    <= '0;
          tss   <= 8'd0;
        end
        ACT_TRIG: begin
          hd  <= hd + PTR_W'(1);
          tss <= tss_inc;
          tc  <= tc_inc;
          if (st == ST_NOSYNC && 8'(tc_inc) >= 8'(req_teeth)) begin
            st <= ST_RPM;
          end
          if (st == ST_SYNC) begin
            angle <= ang_wrap;
          end
        end
        ACT_SYNC: begin
          if (mode) begin
            if (st == ST_RPM) begin
              st    <= ST_SYNC;
              angle <= 10'd0;
            end else if (st == ST_SYNC) begin
              if (tss == teeth_cyc) begin
                angle <= 10'd0;
              end else begin
                st   <= ST_NOSYNC;
                loss <= LOSS_LOW;
              end
            end
            tss <= 8'd0;
          end
        end
        ACT_IGNORE: ;
        default:    ;
      endcase
    end else if (cmd.take_rpm) begin
      rpm <= quot;
    end else if (cmd.zero_rpm) begin
      rpm <= 16'd0;
    end else if (cmd.chk) begin
      if (var_fail) begin
        st   <= ST_NOSYNC;
        loss <= LOSS_VARIATION;
      end
      if (tss > teeth_cyc) begin
        st   <= ST_NOSYNC;
        loss <= LOSS_HIGH;
      end
      expiry <= t0 + diff + (diff >> 1);
    end else if (cmd.post) begin
      if (act_reg == ACT_TRIG || (act_reg == ACT_SYNC && mode)) begin
        if (st == ST_SYNC || (!mode && st == ST_RPM)) begin
          st        <= ST_SYNC;
          valid     <= 1'b1;
          last_time <= t0;
          if (!mode) begin
            tss <= 8'd0;
          end
        end else if (old_st == ST_SYNC) begin
          valid <= 1'b0;
          st    <= ST_NOSYNC;
          tc    <= '0;
          tss   <= 8'd0;
        end
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    if (push) begin
      t0 <= req.event_time;
    end
    if (cmd.ld_deg_slice) begin
      deg <= DEG_W'(dpt);
    end else if (cmd.ld_deg_win) begin
      deg <= DEG_W'(dpt) * DEG_W'(w_m1[CNT_W-1:0]);
    end
    if (cmd.ld_diff) begin
      diff <= diff_cur;
    end
    if (cmd.take_slice) begin
      slice <= quot;
    end
    if (cmd.mul_chk) begin
      up_lim <= 33'(rpm) * 33'(up_f);
      lo_lim <= 33'(rpm) * 33'(lo_f);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.sync_state      <= st;
      res.position_valid  <= valid;
      res.loss_reason     <= loss;
      res.engine_rpm      <= rpm;
      res.crank_angle     <= angle;
      res.expiry_time     <= expiry;
      res.last_tooth_time <= last_time;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/crank_trigger_sync_decoder.sv
// Requests are handled one at a time: events that need no rpm update skip the divider;
// a trigger tooth with rpm known runs one or two serial divisions (tooth slice, then window).
// A new request is taken only after the previous result is loaded into the output register.
// A finished result waits in the output register while the next request enters.
// Reset (rst, synchronous, active high) clears state; tooth history is unset.
`timescale 1ns / 1ps
`default_nettype none
module crank_trigger_sync_decoder
  import ctsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  ctsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ctsd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // angle stays reduced
  a_angle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.crank_angle < 10'd720))
    else $error("crank angle not reduced");

  // position valid only with full sync
  a_valid_sync: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.position_valid) |-> (res.sync_state == ST_SYNC))
    else $error("position valid without sync");

  // a result is never produced in the cycle after a request was possible
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(req_ready))
    else $error("result loaded while idle");

endmodule
`default_nettype wire

>>> bench/crank_trigger_sync_decoder_test.sv
`timescale 1ns / 1ps
module crank_trigger_sync_decoder_test;
  import ctsd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  crank_trigger_sync_decoder dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder configuration as the testbench believes it
  int unsigned mode_c, req_teeth_c, deg_c, window_c, cycle_teeth_c, min_rpm_c, max_chg_c;

  // decoder state tracked alongside the block
  logic [31:0] tooth_hist [HISTORY_DEPTH];
  sync_t       sync_st;
  int unsigned teeth_seen, teeth_since;
  logic [9:0]  angle_q;
  logic [15:0] rpm_q;
  logic [2:0]  loss_q;
  logic        valid_q;
  logic [31:0] expiry_q, last_time_q;

  req_t  pending_events [$];
  res_t  decoded_states [$];
  int    events_queued = 0;
  int    events_taken = 0;
  int    states_seen = 0;
  int    mismatches = 0;
  bit    req_taken = 1'b0;
  int    send_idle = 0;
  int    recv_idle = 0;
  bit    hold_go = 1'b0;
  int    hold_left = 0;
  logic [31:0] clock_ticks = 32'd0;

  function automatic logic [15:0] tooth_rpm(logic [31:0] diff, longint unsigned deg);
    longint unsigned q;
    if (diff == 32'd0) return 16'hFFFF;
    q = (64'(TICKS_PER_SECOND) * deg) / (64'd6 * 64'(diff));
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic void drop_sync();
    valid_q = 1'b0;
    sync_st = ST_NOSYNC;
    teeth_seen = 0;
    teeth_since = 0;
  endfunction

  // refresh rpm, check variation and tooth count, set expiry
  function automatic void refresh_rpm();
    logic [31:0] diff;
    logic [15:0] slice;
    int unsigned w;
    longint unsigned s, up, lo;
    diff = tooth_hist[0] - tooth_hist[1];
    slice = tooth_rpm(diff, deg_c);
    w = (teeth_seen < window_c) ? teeth_seen : window_c;
    if (w > 1)
      rpm_q = tooth_rpm(tooth_hist[0] - tooth_hist[w-1], longint'(deg_c) * (w - 1));
    else
      rpm_q = 16'd0;
    s = longint'(slice) << 16;
    up = longint'(rpm_q) * (65536 + max_chg_c);
    lo = longint'(rpm_q) * (65536 - max_chg_c);
    if (slice <= min_rpm_c || s > up || s < lo) begin
      sync_st = ST_NOSYNC;
      loss_q = LOSS_VARIATION;
    end
    if (teeth_since > cycle_teeth_c) begin
      sync_st = ST_NOSYNC;
      loss_q = LOSS_HIGH;
    end
    expiry_q = tooth_hist[0] + diff + (diff >> 1);
  endfunction

  function automatic void take_tooth(logic [31:0] t);
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) tooth_hist[i] = tooth_hist[i-1];
    tooth_hist[0] = t;
    if (teeth_since < 255) teeth_since++;
    if (teeth_seen < HISTORY_DEPTH) teeth_seen++;
    if (sync_st == ST_NOSYNC && teeth_seen >= req_teeth_c) sync_st = ST_RPM;
    if (sync_st == ST_SYNC) angle_q = 10'((32'(angle_q) + deg_c) % 720);
    if (sync_st != ST_NOSYNC) refresh_rpm();
  endfunction

  function automatic void take_sync_tooth();
    if (sync_st == ST_RPM) begin
      sync_st = ST_SYNC;
      angle_q = 10'd0;
    end else if (sync_st == ST_SYNC) begin
      if (teeth_since == cycle_teeth_c) begin
        angle_q = 10'd0;
      end else begin
        sync_st = ST_NOSYNC;
        loss_q = LOSS_LOW;
      end
    end
    teeth_since = 0;
  endfunction

  // advance the tracked decoder by one event and return the state it reports
  function automatic res_t decode_event(req_t ev);
    sync_t prior;
    res_t  r;
    prior = sync_st;
    if (ev.action == ACT_EXPIRY) begin
      loss_q = LOSS_EXPIRED;
      drop_sync();
    end else if (ev.action == ACT_IGNORE) begin
      // no change
    end else if (mode_c == 0) begin
      if (ev.action == ACT_TRIG) begin
        take_tooth(ev.event_time);
        if (sync_st != ST_NOSYNC) begin
          sync_st = ST_SYNC;
          valid_q = 1'b1;
          last_time_q = ev.event_time;
          teeth_since = 0;
        end else if (prior == ST_SYNC) begin
          drop_sync();
        end
      end
    end else begin
      if (ev.action == ACT_TRIG) take_tooth(ev.event_time);
      else take_sync_tooth();
      if (sync_st == ST_SYNC) begin
        valid_q = 1'b1;
        last_time_q = tooth_hist[0];
      end else if (prior == ST_SYNC) begin
        drop_sync();
      end
    end
    r.sync_state = sync_st;
    r.position_valid = valid_q;
    r.loss_reason = loss_q;
    r.engine_rpm = rpm_q;
    r.crank_angle = angle_q;
    r.expiry_time = expiry_q;
    r.last_tooth_time = last_time_q;
    return r;
  endfunction

  // offer requests at the falling edge
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        req <= pending_events.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // stall the result side, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // predict on acceptance, check each result against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    req_taken = req_valid && req_ready && !rst;
    if (!rst && res_valid && res_ready) begin
      states_seen++;
      if (decoded_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res);
      end else begin
        want = decoded_states.pop_front();
        if (res.sync_state !== want.sync_state || res.position_valid !== want.position_valid ||
            res.loss_reason !== want.loss_reason || res.engine_rpm !== want.engine_rpm ||
            res.crank_angle !== want.crank_angle || res.expiry_time !== want.expiry_time ||
            res.last_tooth_time !== want.last_tooth_time) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, res);
        end
      end
    end
    if (req_taken) begin
      events_taken++;
      decoded_states.push_back(decode_event(req));
    end
  end

  task automatic add_event(act_t a, logic [31:0] t);
    req_t e;
    e.action = a;
    e.event_time = t;
    pending_events.push_back(e);
    events_queued++;
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    case (idx)
      CFG_MODE:       mode_c = val;
      CFG_REQ_TEETH:  req_teeth_c = val;
      CFG_DEG_TOOTH:  deg_c = val;
      CFG_RPM_WINDOW: window_c = val;
      CFG_TEETH_CYC:  cycle_teeth_c = val;
      CFG_MIN_RPM:    min_rpm_c = val;
      CFG_MAX_CHANGE: max_chg_c = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(int unsigned m, int unsigned rq, int unsigned dg, int unsigned wn,
                         int unsigned tc, int unsigned mn, int unsigned mx);
    write_reg(CFG_MODE, m);
    write_reg(CFG_REQ_TEETH, rq);
    write_reg(CFG_DEG_TOOTH, dg);
    write_reg(CFG_RPM_WINDOW, wn);
    write_reg(CFG_TEETH_CYC, tc);
    write_reg(CFG_MIN_RPM, mn);
    write_reg(CFG_MAX_CHANGE, mx);
  endtask

  // mostly tooth runs (a full cycle plus sync in mode 1, random length in mode 0), with some noise and expiries
  task automatic add_engine_run(int n);
    int made, pick, k, gap, jit;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        add_event(act_t'($urandom_range(0, 3)), $urandom);
        made++;
      end else if (pick < 10) begin
        add_event(ACT_EXPIRY, clock_ticks);
        made++;
      end else begin
        if (mode_c == 0) begin
          k = $urandom_range(1, 40);
        end else begin
          k = cycle_teeth_c;
          pick = $urandom_range(0, 9);
          if (pick == 0) k = k + 1;
          else if (pick == 1 && k > 1) k = k - 1;
        end
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(300, 60000);
        for (int i = 0; i < k && made < n; i++) begin
          jit = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, gap / 8) - gap / 16;
          clock_ticks = clock_ticks + gap + jit;
          add_event(ACT_TRIG, clock_ticks);
          made++;
        end
        if (mode_c != 0 && made < n) begin
          add_event(ACT_SYNC, clock_ticks);
          made++;
        end
      end
    end
  endtask

  task automatic drain();
    while (events_taken != events_queued || states_seen != events_taken) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_idle(int ph);
    case (ph % 4)
      0: begin send_idle = 0;  recv_idle = 0;  end
      1: begin send_idle = 63; recv_idle = 0;  end
      2: begin send_idle = 0;  recv_idle = 63; end
      default: begin send_idle = 35; recv_idle = 35; end
    endcase
  endtask

  initial begin
    mode_c = 0; req_teeth_c = 4; deg_c = 90; window_c = 3;
    cycle_teeth_c = 8; min_rpm_c = 0; max_chg_c = 32768;
    for (int i = 0; i < HISTORY_DEPTH; i++) tooth_hist[i] = '0;
    sync_st = ST_NOSYNC; teeth_seen = 0; teeth_since = 0;
    angle_q = '0; rpm_q = '0; loss_q = LOSS_NONE; valid_q = 1'b0;
    expiry_q = '0; last_time_q = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, reaching sync, ignored events, zero gap, wrap, expiry
    set_idle(0);
    add_event(ACT_TRIG, 32'd0);
    add_event(ACT_TRIG, 32'd1000);
    add_event(ACT_TRIG, 32'd2000);
    add_event(ACT_TRIG, 32'd3000);
    add_event(ACT_TRIG, 32'd4000);
    add_event(ACT_SYNC, 32'd4100);
    add_event(ACT_IGNORE, 32'hFFFF_FFFF);
    add_event(ACT_TRIG, 32'd4000);
    add_event(ACT_TRIG, 32'hFFFF_FF00);
    add_event(ACT_TRIG, 32'h0000_0100);
    add_event(ACT_TRIG, 32'h8000_0100);
    add_event(ACT_EXPIRY, 32'h0);
    for (int i = 1; i <= 5; i++) add_event(ACT_TRIG, 32'h8000_0000 + i * 700);
    drain();
    clock_ticks = 32'hFFF0_0000;

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_all(1, 2, 1, 1, 1, 0, 0);
        2: set_all(1, 32, 720, 32, 255, 65535, 65535);
        3: set_all(1, 4, 30, 4, 12, 100, 16384);
        4: set_all(0, 3, 6, 8, 36, 0, 65535);
        default: set_all(1, 6, 10, 16, 36, 50, 8000);
      endcase
      set_idle(ph);
      if (ph == 3) begin
        @(posedge clk);
        hold_go = 1'b1;
      end
      add_engine_run(ph == 2 ? 250 : 360);
      drain();
    end

    if (mismatches == 0 && decoded_states.size() == 0)
      $display("crank_trigger_sync_decoder_test OK");
    else
      $display("crank_trigger_sync_decoder_test NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("crank_trigger_sync_decoder_test NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ctsd_pkg.sv
rtl/core/ctsd_ram.sv
rtl/core/ctsd_div.sv
rtl/core/ctsd_ctrl.sv
rtl/core/ctsd_dp.sv
rtl/core/crank_trigger_sync_decoder.sv
bench/crank_trigger_sync_decoder_test.sv
